/* design/scmpd_pkg.sv */
// package for the sound card mailbox, pager and dac block
// operation and port codes, register indexes, reset values and shared types
// no dependencies
package scmpd_pkg;

   // operation codes of a request beat
   localparam logic [2:0] OP_HOST_CMD_WR  = 3'd0;
   localparam logic [2:0] OP_HOST_DATA_WR = 3'd1;
   localparam logic [2:0] OP_HOST_STAT_RD = 3'd2;
   localparam logic [2:0] OP_HOST_OUT_RD  = 3'd3;
   localparam logic [2:0] OP_PORT_RD      = 3'd4;
   localparam logic [2:0] OP_PORT_WR      = 3'd5;
   localparam logic [2:0] OP_MEM_RD       = 3'd6;
   localparam logic [2:0] OP_MEM_WR       = 3'd7;

   // coprocessor port numbers (low nibble)
   localparam logic [3:0] PORT_PAGE     = 4'd0;
   localparam logic [3:0] PORT_CMD      = 4'd1;
   localparam logic [3:0] PORT_DATA     = 4'd2;
   localparam logic [3:0] PORT_REPLY    = 4'd3;
   localparam logic [3:0] PORT_STATUS   = 4'd4;
   localparam logic [3:0] PORT_CLR_CMD  = 4'd5;
   localparam logic [3:0] PORT_VOL0     = 4'd6;
   localparam logic [3:0] PORT_VOL1     = 4'd7;
   localparam logic [3:0] PORT_VOL2     = 4'd8;
   localparam logic [3:0] PORT_VOL3     = 4'd9;
   localparam logic [3:0] PORT_DATA_SET = 4'd10;
   localparam logic [3:0] PORT_CMD_SET  = 4'd11;

   // configuration register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_MASK = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO    = 4'd1;

   // reset values
   localparam logic [4:0] PAGE_MASK_RESET = 5'd15;
   localparam logic [7:0] STATUS_RESET    = 8'h7e;

   // status flag bits
   localparam logic [7:0] STAT_DATA_FLAG  = 8'h80;
   localparam logic [7:0] STAT_CMD_FLAG   = 8'h01;

   // byte returned when an access reads nothing
   localparam logic [7:0] NO_DATA = 8'hff;

   // dac midpoint
   localparam logic [7:0] DAC_MID = 8'h80;

   // one request beat
   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  port;
      logic [15:0] address;
      logic [7:0]  value;
   } item_type;

   typedef logic [5:0] volume_type;
   typedef logic [7:0] level_type;

   // translated memory access
   typedef struct packed {
      logic        is_ram;
      logic [5:0]  index;
   } bank_type;

endpackage

/* design/scmpd_pager.sv */
// coprocessor address to rom/ram bank translation
// depends on scmpd_pkg
module scmpd_pager #(
   parameter int RAM_BANKS = 32
) (
   input  logic [15:0]         address,
   input  logic [7:0]          page_select,
   input  logic [4:0]          page_mask,
   output scmpd_pkg::bank_type bank
);
   import scmpd_pkg::*;

   // bank number stays below 64, so 63 / RAM_BANKS compare-subtract steps do the wrap
   localparam int MOD_STEPS = 63 / RAM_BANKS;
   localparam logic [6:0] BANKS = 7'(RAM_BANKS);

   logic [1:0] seg;
   logic [4:0] page;
   logic [6:0] raw_bank;
   logic [6:0] wrap_bank;
   logic       is_ram;

   assign seg  = address[15:14];
   assign page = page_select[4:0] & page_mask;

   // segment decode
   always_comb begin
      unique case (seg)
         2'd0: begin
            is_ram   = 1'b0;
            raw_bank = 7'd0;
         end
         2'd1: begin
            is_ram   = 1'b1;
            raw_bank = 7'(page_mask);
         end
         default: begin
            if (page == 5'd0) begin
               is_ram   = 1'b0;
               raw_bank = 7'(seg[0]);
            end else begin
               is_ram   = 1'b1;
               raw_bank = {1'b0, page - 5'd1, seg[0]};
            end
         end
      endcase
   end

   // ram bank wraps at the installed bank count
   always_comb begin
      wrap_bank = raw_bank;
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (is_ram && (wrap_bank >= BANKS)) wrap_bank = wrap_bank - BANKS;
      end
   end

   assign bank.is_ram = is_ram;
   assign bank.index  = wrap_bank[5:0];

endmodule

/* design/scmpd_regs.sv */
// host mailbox registers, status flags, page register and channel volumes
// depends on scmpd_pkg
module scmpd_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  scmpd_pkg::item_type   item,
   output logic [7:0]            read_data,
   output logic [7:0]            page_select,
   output scmpd_pkg::volume_type volume [4]
);
   import scmpd_pkg::*;

   logic [7:0] command_ff, command_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] reply_ff, reply_in;
   logic [7:0] page_ff, page_in;
   volume_type volume_ff [4];
   volume_type volume_in [4];

   // status side effect shared by port reads and writes 10 and 11
   function automatic logic [7:0] status_side(input logic [3:0] p, input logic [7:0] st,
                                             input logic [7:0] pg, input volume_type v0);
      logic [7:0] r;
      r = st;
      if (p == PORT_DATA_SET) begin
         if (pg[0]) r = st & ~STAT_DATA_FLAG;
         else       r = st | STAT_DATA_FLAG;
      end else begin
         if (v0[5]) r = st | STAT_CMD_FLAG;
         else       r = st & ~STAT_CMD_FLAG;
      end
      return r;
   endfunction

   // next state and read byte for one beat
   always_comb begin
      command_in = command_ff;
      data_in    = data_ff;
      status_in  = status_ff;
      reply_in   = reply_ff;
      page_in    = page_ff;
      volume_in  = volume_ff;
      read_data  = NO_DATA;
      unique case (item.operation)
         OP_HOST_CMD_WR: begin
            command_in = item.value;
            status_in  = status_ff | STAT_CMD_FLAG;
         end
         OP_HOST_DATA_WR: begin
            data_in   = item.value;
            status_in = status_ff | STAT_DATA_FLAG;
         end
         OP_HOST_STAT_RD: read_data = status_ff;
         OP_HOST_OUT_RD: begin
            status_in = status_ff & ~STAT_DATA_FLAG;
            read_data = reply_ff;
         end
         OP_PORT_RD: begin
            unique case (item.port)
               PORT_CMD:    read_data = command_ff;
               PORT_DATA: begin
                  status_in = status_ff & ~STAT_DATA_FLAG;
                  read_data = data_ff;
               end
               PORT_REPLY:   status_in = status_ff | STAT_DATA_FLAG;
               PORT_STATUS:  read_data = status_ff;
               PORT_CLR_CMD: status_in = status_ff & ~STAT_CMD_FLAG;
               PORT_DATA_SET, PORT_CMD_SET:
                  status_in = status_side(item.port, status_ff, page_ff, volume_ff[0]);
               default: ;
            endcase
         end
         OP_PORT_WR: begin
            unique case (item.port)
               PORT_PAGE:  page_in = item.value;
               PORT_DATA:  status_in = status_ff & ~STAT_DATA_FLAG;
               PORT_REPLY: begin
                  status_in = status_ff | STAT_DATA_FLAG;
                  reply_in  = item.value;
               end
               PORT_CLR_CMD: status_in = status_ff & ~STAT_CMD_FLAG;
               PORT_VOL0: volume_in[0] = item.value[5:0];
               PORT_VOL1: volume_in[1] = item.value[5:0];
               PORT_VOL2: volume_in[2] = item.value[5:0];
               PORT_VOL3: volume_in[3] = item.value[5:0];
               PORT_DATA_SET, PORT_CMD_SET:
                  status_in = status_side(item.port, status_ff, page_ff, volume_ff[0]);
               default: ;
            endcase
         end
         OP_MEM_RD: read_data = item.value;
         OP_MEM_WR: read_data = NO_DATA;
         default: ;
      endcase
   end

   // state registers, updated once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= '0;
         data_ff    <= '0;
         status_ff  <= STATUS_RESET;
         reply_ff   <= '0;
         page_ff    <= '0;
         for (int i = 0; i < 4; i++) volume_ff[i] <= '0;
      end else if (fire) begin
         command_ff <= command_in;
         data_ff    <= data_in;
         status_ff  <= status_in;
         reply_ff   <= reply_in;
         page_ff    <= page_in;
         volume_ff  <= volume_in;
      end
   end

   assign page_select = page_ff;
   assign volume      = volume_ff;

endmodule

/* design/scmpd_dac.sv */
// four dac channel levels with volume scaling and the left/right mix
// depends on scmpd_pkg
module scmpd_dac (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  scmpd_pkg::item_type   item,
   input  scmpd_pkg::volume_type volume [4],
   input  logic                  stereo,
   output logic [7:0]            mix_left,
   output logic [7:0]            mix_right
);
   import scmpd_pkg::*;

   level_type          level_ff [4];
   level_type          level_in;
   logic [1:0]         chan;
   logic               capture;
   logic signed [7:0]  sample;
   logic signed [14:0] prod;
   logic               neg;
   logic [13:0]        mag;
   logic [14:0]        approx;
   logic [7:0]         quot_est;
   logic [13:0]        rem;
   logic [7:0]         quot;
   logic [8:0]         pair_lo;
   logic [8:0]         pair_hi;
   logic [9:0]         sum_all;

   // capture on a memory read in 6000h-7fffh, channel from address bits 9..8
   assign capture = (item.operation == OP_MEM_RD) && (item.address[15:13] == 3'b011);
   assign chan    = item.address[9:8];

   // signed sample times volume
   assign sample = $signed(item.value ^ DAC_MID);
   assign prod   = sample * $signed({1'b0, volume[chan]});
   assign neg    = prod[14];
   assign mag    = neg ? 14'(-prod) : prod[13:0];

   // magnitude / 63: series estimate never overshoots, then one correction
   assign approx   = {1'b0, mag} + 15'(mag >> 6) + 15'(mag >> 12);
   assign quot_est = 8'(approx >> 6);
   assign rem      = 14'(mag - (14'(quot_est) << 6) + 14'(quot_est));
   assign quot     = (rem >= 14'd63) ? quot_est + 8'd1 : quot_est;

   assign level_in = neg ? DAC_MID - quot : DAC_MID + quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) level_ff[i] <= '0;
      end else if (fire && capture) begin
         level_ff[chan] <= level_in;
      end
   end

   // mix of the levels left by the last processed beat
   assign pair_lo = {1'b0, level_ff[0]} + {1'b0, level_ff[1]};
   assign pair_hi = {1'b0, level_ff[2]} + {1'b0, level_ff[3]};
   assign sum_all = {1'b0, pair_lo} + {1'b0, pair_hi};

   assign mix_left  = stereo ? pair_lo[8:1] : sum_all[9:2];
   assign mix_right = stereo ? pair_hi[8:1] : sum_all[9:2];

endmodule

/* design/sound_card_mailbox_pager_dac.sv */
// top level of the sound card mailbox, pager and dac block
// depends on scmpd_pkg, scmpd_regs, scmpd_pager, scmpd_dac
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | valid ready operation port address value | in
//   rsp     | valid ready read_data bank_* write_allowed mix_* | out
//   csr     | valid ready index data                  | in
//
// a request beat is registered in the input register, processed from it and
// lands in the result register; one beat per cycle while rsp does not stall
// the result register and the input register part the two sides, so a new
// beat is taken while a result waits; a stalled rsp holds the input register
// synchronous reset clears handshake and dac levels, resets mailbox and csrs
// csr writes are taken every cycle and apply at once
module sound_card_mailbox_pager_dac #(
   parameter int RAM_BANKS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_operation,
   input  logic [3:0]                      req_port,
   input  logic [15:0]                     req_address,
   input  logic [7:0]                      req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_read_data,
   output logic                            rsp_bank_is_ram,
   output logic [5:0]                      rsp_bank_index,
   output logic [13:0]                     rsp_bank_offset,
   output logic                            rsp_write_allowed,
   output logic [7:0]                      rsp_mix_left,
   output logic [7:0]                      rsp_mix_right,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [scmpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data
);
   import scmpd_pkg::*;

   logic       in_valid_ff;
   item_type   item_ff;
   logic       fire;
   logic       out_valid_ff;
   logic [4:0] page_mask_ff;
   logic       stereo_ff;

   logic [7:0] regs_read;
   logic [7:0] page_select;
   volume_type volume [4];
   bank_type   bank;
   logic       is_mem;

   logic [7:0]  read_data_ff;
   logic        bank_is_ram_ff;
   logic [5:0]  bank_index_ff;
   logic [13:0] bank_offset_ff;
   logic        write_allowed_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_mask_ff <= PAGE_MASK_RESET;
         stereo_ff    <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_PAGE_MASK) page_mask_ff <= csr_data[4:0];
         else if (csr_index == CSR_STEREO) stereo_ff <= csr_data[0];
      end
   end

   // pipeline handshake
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= '{operation: req_operation, port: req_port,
                      address: req_address, value: req_value};
      end
   end

   scmpd_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (item_ff),
      .read_data   (regs_read),
      .page_select (page_select),
      .volume      (volume)
   );

   scmpd_pager #(
      .RAM_BANKS (RAM_BANKS)
   ) u_pager (
      .address     (item_ff.address),
      .page_select (page_select),
      .page_mask   (page_mask_ff),
      .bank        (bank)
   );

   scmpd_dac u_dac (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .volume    (volume),
      .stereo    (stereo_ff),
      .mix_left  (rsp_mix_left),
      .mix_right (rsp_mix_right)
   );

   assign is_mem = (item_ff.operation == OP_MEM_RD) || (item_ff.operation == OP_MEM_WR);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         read_data_ff     <= regs_read;
         bank_is_ram_ff   <= is_mem & bank.is_ram;
         bank_index_ff    <= is_mem ? bank.index : 6'd0;
         bank_offset_ff   <= is_mem ? item_ff.address[13:0] : 14'd0;
         write_allowed_ff <= (item_ff.operation == OP_MEM_WR) & bank.is_ram;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = read_data_ff;
   assign rsp_bank_is_ram   = bank_is_ram_ff;
   assign rsp_bank_index    = bank_index_ff;
   assign rsp_bank_offset   = bank_offset_ff;
   assign rsp_write_allowed = write_allowed_ff;

endmodule

/* design/scmpd_checker.sv */
// port-level checks for the sound card mailbox, pager and dac block
// depends on scmpd_pkg; bound to sound_card_mailbox_pager_dac
module scmpd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_read_data,
   input logic                            rsp_bank_is_ram,
   input logic [5:0]                      rsp_bank_index,
   input logic                            rsp_write_allowed
);
   import scmpd_pkg::*;

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                  && $stable(rsp_bank_index))
      else $error("stalled result beat changed");

   // writes only go through to ram
   a_rom_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_allowed |-> rsp_bank_is_ram)
      else $error("write allowed on a rom bank");

   // rom has only banks 0 and 1
   a_rom_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bank_is_ram |-> rsp_bank_index <= 6'd1)
      else $error("rom bank index out of range");

endmodule

bind sound_card_mailbox_pager_dac scmpd_checker u_scmpd_checker (.*);
